### src/fniw_pkg.sv
// ----------------------------------------------------------------------------
// fniw_pkg
// Shared constants and types for the first-negative-in-window block.
// ----------------------------------------------------------------------------
package fniw_pkg;

    localparam int DEF_MAX_WINDOW  = 256;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int WINDOW_W   = 9;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_SEL_LSB = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 9'd1;

    typedef enum logic [0:0] {
        REG_WINDOW_SIZE = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic valid;
        logic found;
    } res_ctrl_t;

endpackage

### src/fniw_in_if.sv
// ----------------------------------------------------------------------------
// fniw_in_if
// Sample channel: one signed sample word and its end-of-sequence mark.
// ----------------------------------------------------------------------------
interface fniw_in_if #(
    parameter int SAMPLE_BITS = fniw_pkg::DEF_SAMPLE_BITS
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink   (input valid, input sample, input end_of_sequence, output ready);

endinterface

### src/fniw_out_if.sv
// ----------------------------------------------------------------------------
// fniw_out_if
// Result channel: oldest negative sample in the window and its found flag.
// ----------------------------------------------------------------------------
interface fniw_out_if #(
    parameter int SAMPLE_BITS = fniw_pkg::DEF_SAMPLE_BITS
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] first_negative;
    logic                          found;

    modport source (output valid, output first_negative, output found, input ready);
    modport sink   (input valid, input first_negative, input found, output ready);

endinterface

### src/first_negative_in_window.sv
// ----------------------------------------------------------------------------
// first_negative_in_window
// Reports the oldest negative sample in a sliding window over a sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   samples  - sink channel; one signed sample word per handshake, with an
//              end_of_sequence mark on the last word of a sequence.
//   results  - source channel; first_negative and found for each word once
//              window_size words of the current sequence have arrived.
//   APB      - window_size at byte address 0; write only while idle.
// Timing: one word per cycle sustained while samples.ready is high. A result
//   is registered in the output buffer; the queue step (one pop, one push,
//   one prefetch read of the memory port) completes when its word is taken.
// Reset: queue pointers, counts and the window register (to 1) clear at
//   once; the queue memory is not cleared and needs no clearing pass.
// Stall: a two-entry output buffer holds results; samples.ready drops only
//   when both entries are full, and rises when results takes a word.
// end_of_sequence: the queue and position counters clear after that word.
// ----------------------------------------------------------------------------
module first_negative_in_window #(
    parameter int MAX_WINDOW  = fniw_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = fniw_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fniw_in_if.sink                             samples,
    fniw_out_if.source                          results,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fniw_pkg::PADDR_W-1:0]        paddr,
    input  logic [fniw_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fniw_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [fniw_pkg::WINDOW_W-1:0] window_size_reg, window_size_next;
    fniw_pkg::reg_idx_t            reg_sel;
    logic                          cfg_wr;
    logic                          step;
    logic                          core_ready;
    fniw_pkg::res_ctrl_t           res_ctrl;
    logic signed [SAMPLE_BITS-1:0] res_value;

    assign reg_sel = fniw_pkg::reg_idx_t'(paddr[fniw_pkg::REG_SEL_LSB]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        window_size_next = window_size_reg;
        prdata           = '0;
        unique case (reg_sel)
            fniw_pkg::REG_WINDOW_SIZE:
            begin
                prdata = fniw_pkg::CFG_DATA_W'(window_size_reg);
                if (cfg_wr)
                begin
                    window_size_next = pwdata[fniw_pkg::WINDOW_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= fniw_pkg::WINDOW_RESET;
        end
        else
        begin
            window_size_reg <= window_size_next;
        end
    end

    assign samples.ready = core_ready;
    assign step          = samples.valid && core_ready;

    fniw_core #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .sample          (samples.sample),
        .end_of_sequence (samples.end_of_sequence),
        .window_size     (window_size_reg),
        .res_ctrl        (res_ctrl),
        .res_value       (res_value)
    );

    fniw_skid #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   (res_ctrl),
        .in_value  (res_value),
        .in_ready  (core_ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_value (results.first_negative),
        .out_found (results.found)
    );

endmodule

### src/fniw_core.sv
// ----------------------------------------------------------------------------
// fniw_core
// Queue of negative samples held in a synchronous memory, with the front
// entry in registers and the entry behind it prefetched every cycle.
// ----------------------------------------------------------------------------
module fniw_core #(
    parameter int MAX_WINDOW  = fniw_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = fniw_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic                               end_of_sequence,
    input  logic [fniw_pkg::WINDOW_W-1:0]      window_size,
    output fniw_pkg::res_ctrl_t                res_ctrl,
    output logic signed [SAMPLE_BITS-1:0]      res_value
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = $clog2(2 * MAX_WINDOW);

    localparam logic [AW-1:0] PTR_LAST = AW'(MAX_WINDOW - 1);
    localparam logic [PW-1:0] POS_LAST = PW'(2 * MAX_WINDOW - 1);
    localparam logic [PW:0]   POS_MOD  = (PW + 1)'(2 * MAX_WINDOW);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_WINDOW);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + AW'(1);
    endfunction

    logic signed [SAMPLE_BITS-1:0] mem_val [MAX_WINDOW];
    logic [PW-1:0]                 mem_pos [MAX_WINDOW];

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] seen_reg, seen_next;

    logic signed [SAMPLE_BITS-1:0] front_val_reg, front_val_next;
    logic [PW-1:0]                 front_pos_reg, front_pos_next;
    logic signed [SAMPLE_BITS-1:0] rd_val_reg;
    logic [PW-1:0]                 rd_pos_reg;

    logic [CW-1:0] win_eff;
    logic [PW:0]   age_wide;
    logic [PW-1:0] age;
    logic          pop;
    logic          push;
    logic          wr_en;
    logic [CW-1:0] count_ap;
    logic [AW-1:0] head_ap;
    logic [AW-1:0] rd_addr;

    always_comb
    begin
        if (window_size == '0)
        begin
            win_eff = CW'(1);
        end
        else if (32'(window_size) > 32'(MAX_WINDOW))
        begin
            win_eff = CNT_FULL;
        end
        else
        begin
            win_eff = CW'(window_size);
        end

        if (pos_reg >= front_pos_reg)
        begin
            age_wide = {1'b0, pos_reg} - {1'b0, front_pos_reg};
        end
        else
        begin
            age_wide = {1'b0, pos_reg} + POS_MOD - {1'b0, front_pos_reg};
        end
        age = age_wide[PW-1:0];

        pop      = (count_reg != '0) && (age >= PW'(win_eff));
        count_ap = count_reg - CW'(pop);
        head_ap  = pop ? ptr_inc(head_reg) : head_reg;
        push     = sample[SAMPLE_BITS-1] && (count_ap != CNT_FULL);
        wr_en    = step && push;

        if (push && (count_ap == '0))
        begin
            front_val_next = sample;
            front_pos_next = pos_reg;
        end
        else if (pop)
        begin
            front_val_next = rd_val_reg;
            front_pos_next = rd_pos_reg;
        end
        else
        begin
            front_val_next = front_val_reg;
            front_pos_next = front_pos_reg;
        end

        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        if (step)
        begin
            head_next  = head_ap;
            tail_next  = push ? ptr_inc(tail_reg) : tail_reg;
            count_next = count_ap + CW'(push);
            pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);
            seen_next  = (seen_reg < win_eff) ? seen_reg + CW'(1) : seen_reg;
        end

        res_ctrl.valid = step && (seen_next >= win_eff);
        res_ctrl.found = (count_ap + CW'(push)) != '0;
        res_value      = res_ctrl.found ? front_val_next : '0;

        if (step && end_of_sequence)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            pos_next   = '0;
            seen_next  = '0;
        end

        rd_addr = ptr_inc(head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            front_val_reg <= front_val_next;
            front_pos_reg <= front_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_val[tail_reg] <= sample;
            mem_pos[tail_reg] <= pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (tail_reg == rd_addr))
        begin
            rd_val_reg <= sample;
            rd_pos_reg <= pos_reg;
        end
        else
        begin
            rd_val_reg <= mem_val[rd_addr];
            rd_pos_reg <= mem_pos[rd_addr];
        end
    end

endmodule

### src/fniw_skid.sv
// ----------------------------------------------------------------------------
// fniw_skid
// Two-entry output buffer: output register plus one skid entry.
// ----------------------------------------------------------------------------
module fniw_skid #(
    parameter int SAMPLE_BITS = fniw_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fniw_pkg::res_ctrl_t           in_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] in_value,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_value,
    output logic                          out_found
);

    logic                          main_v_reg, main_v_next;
    logic                          skid_v_reg, skid_v_next;
    logic signed [SAMPLE_BITS-1:0] main_val_reg, skid_val_reg;
    logic                          main_fnd_reg, skid_fnd_reg;
    logic                          take;
    logic                          load_main;
    logic                          load_skid;
    logic                          move_skid;

    always_comb
    begin
        take        = main_v_reg && out_ready;
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        load_main   = 1'b0;
        load_skid   = 1'b0;
        move_skid   = 1'b0;
        priority if (skid_v_reg)
        begin
            if (take)
            begin
                move_skid   = 1'b1;
                skid_v_next = 1'b0;
            end
        end
        else if (in_ctrl.valid && main_v_reg && !take)
        begin
            load_skid   = 1'b1;
            skid_v_next = 1'b1;
        end
        else if (in_ctrl.valid)
        begin
            load_main   = 1'b1;
            main_v_next = 1'b1;
        end
        else if (take)
        begin
            main_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_skid)
        begin
            main_val_reg <= skid_val_reg;
            main_fnd_reg <= skid_fnd_reg;
        end
        else if (load_main)
        begin
            main_val_reg <= in_value;
            main_fnd_reg <= in_ctrl.found;
        end
        if (load_skid)
        begin
            skid_val_reg <= in_value;
            skid_fnd_reg <= in_ctrl.found;
        end
    end

    assign in_ready  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_value = main_val_reg;
    assign out_found = main_fnd_reg;

endmodule

### src/fniw_checker.sv
// ----------------------------------------------------------------------------
// fniw_checker
// Port-level checks on the result channel and samples.ready, bound to the top level.
// ----------------------------------------------------------------------------
module fniw_checker #(
    parameter int SAMPLE_BITS = fniw_pkg::DEF_SAMPLE_BITS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] first_negative,
    input logic                          found
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(first_negative) && $stable(found))
        else $error("result word changed while stalled");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> first_negative == '0)
        else $error("value not zero with found clear");

    a_found_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> first_negative[SAMPLE_BITS-1])
        else $error("reported sample is not negative");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input held off with empty output");

endmodule

bind first_negative_in_window fniw_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fniw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (samples.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .first_negative (results.first_negative),
    .found          (results.found)
);
